[hdl/btpl_pkg.sv]
// shared types and microcode rom for the binary trie prefix lookup block
// no dependencies; imported by binary_trie_prefix_lookup
package btpl_pkg;

  // field widths fixed by the stream format
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned RTAG_W  = 16;
  localparam int unsigned IN_DW   = 56;  // address, prefix_len, route_tag, padded
  localparam int unsigned OUT_DW  = 24;  // match_tag, match_len, padded
  localparam int unsigned OUT_UW  = 2;   // status, hit

  // operation codes carried on s_axis_tuser
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // result status codes
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_POOL_FULL = 1'b1;

  // microcode step addresses
  localparam logic [1:0] STEP_IDLE   = 2'd0;
  localparam logic [1:0] STEP_LOOKUP = 2'd1;  // must be STEP_INSERT - 1
  localparam logic [1:0] STEP_INSERT = 2'd2;
  localparam logic [1:0] STEP_DONE   = 2'd3;

  // jump conditions; a false condition holds the step
  typedef enum logic [1:0] {
    COND_ACCEPT    = 2'd0,
    COND_WALK_DONE = 2'd1,
    COND_OUT_FREE  = 2'd2
  } cond_e;

  typedef struct packed {
    logic       ready;     // take an input transfer
    logic       walk_lk;   // lookup walk datapath active
    logic       walk_ins;  // insert walk datapath active
    logic       emit;      // load the output register
    cond_e      cond;
    logic       add_func;  // add the func bit to the target
    logic [1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      STEP_IDLE:   w = '{ready: 1'b1, walk_lk: 1'b0, walk_ins: 1'b0, emit: 1'b0,
                         cond: COND_ACCEPT, add_func: 1'b1, target: STEP_LOOKUP};
      STEP_LOOKUP: w = '{ready: 1'b0, walk_lk: 1'b1, walk_ins: 1'b0, emit: 1'b0,
                         cond: COND_WALK_DONE, add_func: 1'b0, target: STEP_DONE};
      STEP_INSERT: w = '{ready: 1'b0, walk_lk: 1'b0, walk_ins: 1'b1, emit: 1'b0,
                         cond: COND_WALK_DONE, add_func: 1'b0, target: STEP_DONE};
      STEP_DONE:   w = '{ready: 1'b0, walk_lk: 1'b0, walk_ins: 1'b0, emit: 1'b1,
                         cond: COND_OUT_FREE, add_func: 1'b0, target: STEP_IDLE};
      default:     w = '0;
    endcase
    return w;
  endfunction

endpackage

[hdl/binary_trie_prefix_lookup.sv]
// binary trie longest-prefix-match engine: microcoded walk over one node memory
// depends on btpl_pkg (field widths, step addresses, microcode rom)
//
// usage:
//   s_axis carries one operation per transfer. s_axis_tuser is func:
//   0 looks up tdata.address, 1 inserts tdata.address / prefix_len with route_tag.
//   m_axis returns exactly one result per operation, in order. m_axis_tuser holds
//   status (insert failed, node pool exhausted) and hit; tdata holds the longest
//   matching prefix's tag and length, zero on a miss or for an insert.
// timing:
//   one at a time: an item descends at most ADDR_BITS levels (32 at the default),
//   one node memory read per level, then reaches the output register; the next
//   is taken only once that result has been loaded into the output register.
// reset:
//   the trie is empty after reset and no clearing pass is run: nodes are handed
//   out in order by a free counter, a fresh node reads as empty until written,
//   and the root reads as empty until its first write.
// stall:
//   the result stays in the output register while m_axis_tready is low; a
//   following item may walk meanwhile and waits for the register to drain.

module binary_trie_prefix_lookup #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // address [31:0], prefix_len [37:32], route_tag [53:38], zero [55:54]
  input  logic [btpl_pkg::IN_DW-1:0]  s_axis_tdata,
  // func [0]
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // match_tag [15:0], match_len [21:16], zero [23:22]
  output logic [btpl_pkg::OUT_DW-1:0] m_axis_tdata,
  // status [0], hit [1]
  output logic [btpl_pkg::OUT_UW-1:0] m_axis_tuser
);
  import btpl_pkg::*;

  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned TW  = (TAG_BITS < RTAG_W) ? TAG_BITS : RTAG_W;
  // node word: {tag, mark, right, left}
  localparam int unsigned WW  = TW + 1 + 2 * NW;
  localparam int unsigned R_LO = NW;
  localparam int unsigned M_BIT = 2 * NW;
  localparam int unsigned T_LO = 2 * NW + 1;

  // node memory
  logic [WW-1:0] mem [NODE_COUNT];
  logic [WW-1:0] rdata_q;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [NW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // sequencer
  logic [1:0]     upc_q, upc_d;
  ctrl_t          cw;
  logic           in_acc, out_free, walk_done, cond_true;
  logic [1:0]     jump_tgt;

  // walk registers
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q, d_q;
  logic [TW-1:0]     tag_q, best_tag_q;
  logic [LEN_W-1:0]  best_len_q;
  logic              found_q, status_q, fresh_q, root_ok_q;
  logic [NW-1:0]     node_q;
  logic [NW:0]       nf_q;

  // output register
  logic              out_valid_q;
  logic              out_status_q, out_hit_q;
  logic [RTAG_W-1:0] out_tag_q;
  logic [LEN_W-1:0]  out_len_q;

  // entry decode
  logic [WW-1:0]    ent;
  logic [NW-1:0]    ent_left, ent_right, child;
  logic             ent_mark, cur_bit, pool_full, end_here;
  logic [TW-1:0]    ent_tag;
  logic [LEN_W-1:0] bitpos, len_in, len_clip;

  assign cw        = ucode_rom(upc_q);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = cw.ready;

  assign ent       = fresh_q ? '0 : rdata_q;
  assign ent_left  = ent[NW-1:0];
  assign ent_right = ent[R_LO +: NW];
  assign ent_mark  = ent[M_BIT];
  assign ent_tag   = ent[T_LO +: TW];
  assign bitpos    = LEN_W'(ADDR_BITS - 1) - d_q;
  assign cur_bit   = addr_q[bitpos[4:0]];
  assign child     = cur_bit ? ent_right : ent_left;
  assign pool_full = (nf_q >= (NW+1)'(NODE_COUNT));
  assign end_here  = (d_q == len_q);

  assign len_in    = s_axis_tdata[37:32];
  assign len_clip  = (len_in > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : len_in;

  always_comb begin
    walk_done = 1'b0;
    if (cw.walk_lk) begin
      walk_done = (d_q == LEN_W'(ADDR_BITS)) || (child == '0);
    end else if (cw.walk_ins) begin
      walk_done = end_here || ((child == '0) && pool_full);
    end
  end

  always_comb begin
    unique case (cw.cond)
      COND_ACCEPT:    cond_true = in_acc;
      COND_WALK_DONE: cond_true = walk_done;
      COND_OUT_FREE:  cond_true = out_free;
      default:        cond_true = 1'b0;
    endcase
    jump_tgt = cw.target + (cw.add_func ? {1'b0, s_axis_tuser} : 2'd0);
    upc_d    = cond_true ? jump_tgt : upc_q;
  end

  // memory port control
  always_comb begin
    rd_addr = cw.ready ? '0 : child;
    wr_en   = 1'b0;
    wr_addr = node_q;
    wr_data = ent;
    if (cw.walk_ins) begin
      if (end_here) begin
        wr_en   = 1'b1;
        wr_data = {tag_q, 1'b1, ent_right, ent_left};
      end else if (child == '0) begin
        // allocate, or on exhaustion settle a fresh node as empty
        wr_en = 1'b1;
        if (!pool_full) begin
          if (cur_bit) begin
            wr_data = {ent_tag, ent_mark, nf_q[NW-1:0], ent_left};
          end else begin
            wr_data = {ent_tag, ent_mark, ent_right, nf_q[NW-1:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q      <= STEP_IDLE;
      nf_q       <= (NW+1)'(1);
      root_ok_q  <= 1'b0;
      fresh_q    <= 1'b0;
      found_q    <= 1'b0;
      status_q   <= ST_DONE;
      d_q        <= '0;
      node_q     <= '0;
      addr_q     <= '0;
      len_q      <= '0;
      tag_q      <= '0;
      best_tag_q <= '0;
      best_len_q <= '0;
    end else begin
      upc_q <= upc_d;
      if (wr_en && (wr_addr == '0)) begin
        root_ok_q <= 1'b1;
      end
      if (in_acc) begin
        addr_q     <= s_axis_tdata[31:0];
        len_q      <= len_clip;
        tag_q      <= s_axis_tdata[38 +: TW];
        d_q        <= '0;
        node_q     <= '0;
        fresh_q    <= !root_ok_q;
        found_q    <= 1'b0;
        status_q   <= ST_DONE;
        best_tag_q <= '0;
        best_len_q <= '0;
      end
      if (cw.walk_lk) begin
        if (ent_mark) begin
          found_q    <= 1'b1;
          best_tag_q <= ent_tag;
          best_len_q <= d_q;
        end
        if (!walk_done) begin
          node_q  <= child;
          fresh_q <= 1'b0;
          d_q     <= d_q + 1'b1;
        end
      end
      if (cw.walk_ins && !end_here) begin
        if (child != '0) begin
          node_q  <= child;
          fresh_q <= 1'b0;
          d_q     <= d_q + 1'b1;
        end else if (pool_full) begin
          status_q <= ST_POOL_FULL;
        end else begin
          node_q  <= nf_q[NW-1:0];
          fresh_q <= 1'b1;
          nf_q    <= nf_q + 1'b1;
          d_q     <= d_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_hit_q    <= 1'b0;
      out_tag_q    <= '0;
      out_len_q    <= '0;
    end else begin
      if (cw.emit && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_hit_q    <= found_q;
        out_tag_q    <= RTAG_W'(best_tag_q);
        out_len_q    <= best_len_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_len_q, out_tag_q};
  assign m_axis_tuser  = {out_hit_q, out_status_q};

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= (NW+1)'(NODE_COUNT))
    else $error("free counter beyond node pool");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.walk_lk || cw.walk_ins) |-> d_q <= LEN_W'(ADDR_BITS))
    else $error("walk deeper than address width");

  a_fail_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.emit && status_q) |-> pool_full)
    else $error("insert failure with free nodes left");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_hit_q) |-> (out_tag_q == '0 && out_len_q == '0))
    else $error("miss result carries a tag or length");

  a_write_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (upc_q == STEP_INSERT))
    else $error("node write outside an insert walk");
`endif

endmodule

[verif/tb_binary_trie_prefix_lookup.sv]
`timescale 1ns / 1ps
// self-checking testbench for binary_trie_prefix_lookup: directed and random inserts/lookups
// keeps its own trie to predict every result; depends on btpl_pkg and the block only
module tb_binary_trie_prefix_lookup;
  import btpl_pkg::*;

  localparam int unsigned NODES     = 4096;
  localparam int unsigned IDLE_PCT  = 11;
  localparam int unsigned N_RANDOM  = 1500;
  localparam int unsigned STALL_MAX = 2000;
  localparam int unsigned TAIL_CYC  = 40;
  localparam int unsigned MAX_SHOWN = 40;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  plen;
    logic [RTAG_W-1:0] rtag;
  } op_t;

  typedef struct packed {
    logic              status;
    logic              hit;
    logic [RTAG_W-1:0] tag;
    logic [LEN_W-1:0]  len;
  } res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic [OUT_UW-1:0] m_axis_tuser;

  binary_trie_prefix_lookup u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow trie
  logic [11:0]       left_ch  [NODES];
  logic [11:0]       right_ch [NODES];
  logic              marked   [NODES];
  logic [RTAG_W-1:0] stored_tag [NODES];
  int unsigned       free_node;

  op_t  ops_to_send [$];
  res_t results_due [$];
  op_t  cur_op;

  // generator bookkeeping: prefixes inserted so far
  logic [ADDR_W-1:0] gen_pfx_addr [$];
  int unsigned       gen_pfx_len  [$];
  logic [ADDR_W-1:0] bases [16];

  int unsigned n_sent, n_recv, n_insert, n_lookup, n_hit, n_pool_full, err_cnt;
  int unsigned stall_cyc;
  logic steady;

  // no idling on either side through a middle stretch of the run
  assign steady = (n_sent >= 600) && (n_sent < 900);

  function automatic res_t trie_apply(input op_t op);
    res_t        r;
    int unsigned node, d, lim, c;
    logic        b;
    r = '0;
    node = 0;
    if (op.func == OP_INSERT) begin
      n_insert++;
      lim = (op.plen > ADDR_W) ? ADDR_W : op.plen;
      for (d = 0; d < lim; d++) begin
        b = op.addr[ADDR_W-1-d];
        c = b ? right_ch[node] : left_ch[node];
        if (c == 0) begin
          if (free_node >= NODES) begin
            r.status = ST_POOL_FULL;
            n_pool_full++;
            return r;
          end
          c = free_node;
          free_node++;
          if (b) right_ch[node] = c[11:0];
          else left_ch[node] = c[11:0];
        end
        node = c;
      end
      marked[node] = 1'b1;
      stored_tag[node] = op.rtag;
      r.status = ST_DONE;
    end else begin
      n_lookup++;
      d = 0;
      forever begin
        if (marked[node]) begin
          r.hit = 1'b1;
          r.tag = stored_tag[node];
          r.len = d[LEN_W-1:0];
        end
        if (d >= ADDR_W) break;
        c = op.addr[ADDR_W-1-d] ? right_ch[node] : left_ch[node];
        if (c == 0) break;
        node = c;
        d++;
      end
      if (r.hit) n_hit++;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] low_mask(input int unsigned n);
    return (n >= ADDR_W) ? '1 : ((32'h1 << n) - 32'h1);
  endfunction

  task automatic add_op(input logic func, input logic [ADDR_W-1:0] addr,
                        input int unsigned plen, input int unsigned rtag);
    op_t o;
    o.func = func;
    o.addr = addr;
    o.plen = plen[LEN_W-1:0];
    o.rtag = rtag[RTAG_W-1:0];
    ops_to_send.push_back(o);
    if (func == OP_INSERT) begin
      gen_pfx_addr.push_back(addr);
      gen_pfx_len.push_back((plen > ADDR_W) ? ADDR_W : plen);
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (err_cnt < MAX_SHOWN)
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               n_recv, what, got, want);
    err_cnt++;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("unexpected transfer, tuser/tdata", {got.status, got.hit},
                    {got.tag, got.len});
      return;
    end
    want = results_due.pop_front();
    if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
    if (got.hit !== want.hit) flag_mismatch("hit", got.hit, want.hit);
    if (got.tag !== want.tag) flag_mismatch("match_tag", got.tag, want.tag);
    if (got.len !== want.len) flag_mismatch("match_len", got.len, want.len);
  endtask

  task automatic fill_stimulus();
    int unsigned i, k, len, roll;
    logic [ADDR_W-1:0] a;
    // directed: empty trie, default route, host routes, clamping, overwrite, fallback
    add_op(OP_LOOKUP, 32'h0000_0000, 63, 16'hFFFF);
    add_op(OP_INSERT, 32'hC0A8_0000, 16, 16'h1234);
    add_op(OP_LOOKUP, 32'hC0A8_0101, 0, 0);
    add_op(OP_LOOKUP, 32'hC0A9_0000, 0, 0);
    add_op(OP_INSERT, 32'h0000_0000, 0, 16'hFFFF);
    add_op(OP_LOOKUP, 32'hC0A9_0000, 0, 0);
    add_op(OP_INSERT, 32'hFFFF_FFFF, 32, 16'h0000);
    add_op(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0);
    add_op(OP_LOOKUP, 32'hFFFF_FFFE, 0, 0);
    add_op(OP_INSERT, 32'h0000_0000, 63, 16'hA5A5);
    add_op(OP_LOOKUP, 32'h0000_0000, 0, 0);
    add_op(OP_INSERT, 32'hC0A8_0101, 32, 16'h5A5A);
    add_op(OP_LOOKUP, 32'hC0A8_0101, 0, 0);
    add_op(OP_LOOKUP, 32'hC0A8_0102, 0, 0);
    add_op(OP_INSERT, 32'hC0A8_0000, 16, 16'h0001);
    add_op(OP_LOOKUP, 32'hC0A8_FFFF, 0, 0);
    add_op(OP_INSERT, 32'hC0A8_00FF, 24, 16'h8000);
    add_op(OP_LOOKUP, 32'hC0A8_0001, 0, 0);
    add_op(OP_INSERT, 32'h8000_0000, 1, 16'h7FFF);
    add_op(OP_LOOKUP, 32'h8000_0000, 0, 0);
    add_op(OP_INSERT, 32'hFFFF_0000, 33, 16'h0F0F);
    add_op(OP_LOOKUP, 32'hFFFF_0000, 0, 0);
    add_op(OP_LOOKUP, 32'h7FFF_FFFF, 0, 0);

    for (k = 0; k < 16; k++) bases[k] = $urandom;
    // random: clustered prefixes share nodes, scattered long ones drain the pool
    for (i = 0; i < N_RANDOM; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 32) : $urandom_range(33, 63);
        if ($urandom_range(0, 99) < 85)
          a = bases[$urandom_range(0, 15)] ^ ($urandom & low_mask($urandom_range(0, 32)));
        else begin
          a = $urandom;
          len = $urandom_range(24, 32);
        end
        add_op(OP_INSERT, a, len, $urandom_range(0, 65535));
      end else begin
        if (roll < 80) begin
          k = $urandom_range(0, gen_pfx_addr.size() - 1);
          len = gen_pfx_len[k];
          a = (gen_pfx_addr[k] & ~low_mask(ADDR_W - len))
              | ($urandom & low_mask(ADDR_W - len));
        end else if (roll < 90)
          a = bases[$urandom_range(0, 15)] ^ ($urandom & low_mask($urandom_range(0, 32)));
        else
          a = $urandom;
        add_op(OP_LOOKUP, a, $urandom_range(0, 63), $urandom_range(0, 65535));
      end
    end
  endtask

  // driver: one operation per transfer, the prediction taken at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(trie_apply(cur_op));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ops_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_op = ops_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_op.rtag, cur_op.plen, cur_op.addr};
          s_axis_tuser  <= cur_op.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, every result transfer checked in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(res_t'{status: m_axis_tuser[0], hit: m_axis_tuser[1],
                            tag: m_axis_tdata[15:0], len: m_axis_tdata[21:16]});
        n_recv++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cyc = 0;
      end else begin
        stall_cyc++;
        if (stall_cyc >= STALL_MAX) begin
          $display("timeout: no transfer for %0d cycles", STALL_MAX);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    n_sent = 0;
    n_recv = 0;
    n_insert = 0;
    n_lookup = 0;
    n_hit = 0;
    n_pool_full = 0;
    err_cnt = 0;
    stall_cyc = 0;
    free_node = 1;
    for (int unsigned j = 0; j < NODES; j++) begin
      left_ch[j] = '0;
      right_ch[j] = '0;
      marked[j] = 1'b0;
      stored_tag[j] = '0;
    end
    fill_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (ops_to_send.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (results_due.size() != 0) flag_mismatch("results never returned", 0, results_due.size());
    $display("ran %0d operations: %0d inserts (%0d refused on a full node pool), %0d lookups",
             n_sent, n_insert, n_pool_full, n_lookup);
    $display("%0d lookups matched a prefix, %0d nodes in use, %0d mismatches",
             n_hit, free_node, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
